// ===== sv/scfr_pkg.sv =====
package scfr_pkg;

  // Frame constants
  localparam logic [7:0] HDR_BYTE   = 8'hAA;
  localparam logic [7:0] LEN_LIMIT  = 8'd250;
  localparam logic [7:0] FUNC_TRACK = 8'hF1;

  // Distance is scaled down by ten: x / 10 == (x * 52429) >> 19 for any 16-bit x
  localparam logic [15:0] DIST_RECIP = 16'd52429;
  localparam int          DIST_SHIFT = 19;
  localparam int          DIST_W     = 13;

  // Record selector codes carried in the first payload byte
  localparam logic [7:0] SEL_TURN   = 8'd0;
  localparam logic [7:0] SEL_X      = 8'd1;
  localparam logic [7:0] SEL_Y      = 8'd2;
  localparam logic [7:0] SEL_DIST   = 8'd3;
  localparam logic [7:0] SEL_NUMBER = 8'd4;
  localparam logic [7:0] SEL_MODE   = 8'd5;

  // Configuration register indexes
  localparam logic CFG_OWN_ADDR   = 1'b0;
  localparam logic CFG_BCAST_ADDR = 1'b1;

  // Frame bytes 4 to 7, kept by position
  typedef logic [3:0][7:0] window_t;

  // Decoded tracking record
  typedef struct packed {
    logic [7:0]        turn_direction;
    logic [7:0]        turn_angle;
    logic [7:0]        x_direction;
    logic [15:0]       x_offset;
    logic [7:0]        y_direction;
    logic [15:0]       y_offset;
    logic [DIST_W-1:0] distance_units;
    logic [7:0]        recognized_number;
    logic [7:0]        work_mode;
    logic [7:0]        update_count;
  } record_t;

endpackage

// ===== sv/scfr_rx_if.sv =====
interface scfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/scfr_cfg_if.sv =====
interface scfr_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/scfr_res_if.sv =====
interface scfr_res_if;
  logic                       valid;
  logic                       ready;
  logic                       frame_ok;
  logic [7:0]                 turn_direction;
  logic [7:0]                 turn_angle;
  logic [7:0]                 x_direction;
  logic [15:0]                x_offset;
  logic [7:0]                 y_direction;
  logic [15:0]                y_offset;
  logic [scfr_pkg::DIST_W-1:0] distance_units;
  logic [7:0]                 recognized_number;
  logic [7:0]                 work_mode;
  logic [7:0]                 update_count;

  modport source (
    output valid, output frame_ok, output turn_direction, output turn_angle,
    output x_direction, output x_offset, output y_direction, output y_offset,
    output distance_units, output recognized_number, output work_mode,
    output update_count, input ready
  );
  modport sink (
    input valid, input frame_ok, input turn_direction, input turn_angle,
    input x_direction, input x_offset, input y_direction, input y_offset,
    input distance_units, input recognized_number, input work_mode,
    input update_count, output ready
  );
endinterface

// ===== sv/scfr_decode.sv =====
module scfr_decode (
  input  scfr_pkg::window_t window,
  input  scfr_pkg::record_t record,
  output scfr_pkg::record_t record_next
);

  logic [15:0] dist_raw;
  logic [31:0] dist_prod;

  // Distance divided by ten through a reciprocal multiply
  assign dist_raw  = {window[1], window[2]};
  assign dist_prod = dist_raw * scfr_pkg::DIST_RECIP;

  // Update the record field chosen by the selector byte
  always_comb begin
    record_next = record;
    unique case (window[0])
      scfr_pkg::SEL_TURN: begin
        record_next.turn_direction = window[1];
        record_next.turn_angle     = window[2];
        record_next.update_count   = record.update_count + 8'd1;
      end
      scfr_pkg::SEL_X: begin
        record_next.x_direction  = window[1];
        record_next.x_offset     = {window[2], window[3]};
        record_next.update_count = record.update_count + 8'd1;
      end
      scfr_pkg::SEL_Y: begin
        record_next.y_direction  = window[1];
        record_next.y_offset     = {window[2], window[3]};
        record_next.update_count = record.update_count + 8'd1;
      end
      scfr_pkg::SEL_DIST: begin
        record_next.distance_units =
          dist_prod[scfr_pkg::DIST_SHIFT +: scfr_pkg::DIST_W];
        record_next.update_count   = record.update_count + 8'd1;
      end
      scfr_pkg::SEL_NUMBER: begin
        record_next.recognized_number = window[1];
      end
      scfr_pkg::SEL_MODE: begin
        record_next.work_mode = window[2];
      end
      default: begin
        record_next = record;
      end
    endcase
  end

endmodule

// ===== sv/sum_checked_frame_receiver_top.sv =====
// Channel | Role   | Word
// --------+--------+---------------------------------------------------------
// rx      | sink   | one received serial byte (rx_byte)
// cfg     | sink   | register write: index 0 own address, 1 broadcast address
// res     | source | frame_ok and the decoded record, one word per frame end
//
// One byte is taken every cycle while rx is not held off; each byte passes through
// the parser and the record decode combinationally, and the frame result is registered.
// A result appears the cycle after the last checksum byte is taken.
// Outside reset, rx is held off only while a result waits at res and is not being taken.
// Synchronous reset puts the parser in header hunt, clears the record and
// holds off both rx and cfg.
module sum_checked_frame_receiver_top (
  input logic         clk,
  input logic         rst,
  scfr_rx_if.sink     rx,
  scfr_cfg_if.sink    cfg,
  scfr_res_if.source  res
);

  typedef enum logic [6:0] {
    S_HUNT    = 7'b0000001,
    S_ADDR    = 7'b0000010,
    S_FUNC    = 7'b0000100,
    S_LEN     = 7'b0001000,
    S_PAYLOAD = 7'b0010000,
    S_SUM     = 7'b0100000,
    S_SUMSUM  = 7'b1000000
  } state_t;

  state_t            state, state_next;
  logic [7:0]        own_address, broadcast_address;
  logic [7:0]        bytes_remaining, bytes_remaining_next;
  logic [2:0]        payload_index, payload_index_next;
  logic [7:0]        running_sum, running_sum_next;
  logic [7:0]        running_sum_of_sums, running_sum_of_sums_next;
  logic [7:0]        function_id, function_id_next;
  logic              sum_matched, sum_matched_next;
  scfr_pkg::window_t window, window_next;
  scfr_pkg::record_t record, record_next, record_upd;
  logic              res_valid, frame_ok;
  logic              frame_ok_next, result_fire;
  logic              rx_take, keep_byte;
  logic [7:0]        b, sum_add, sos_add;

  // Input is stalled by reset or by a result waiting at the output
  assign rx.ready  = !rst && (!res_valid || res.ready);
  assign rx_take   = rx.valid && rx.ready;
  assign cfg.ready = !rst;
  assign b         = rx.rx_byte;

  assign sum_add = running_sum + b;
  assign sos_add = running_sum_of_sums + sum_add;

  // Frame parser: next state, checksums and window for the incoming word
  always_comb begin
    state_next               = state;
    bytes_remaining_next     = bytes_remaining;
    payload_index_next       = payload_index;
    running_sum_next         = running_sum;
    running_sum_of_sums_next = running_sum_of_sums;
    function_id_next         = function_id;
    sum_matched_next         = sum_matched;
    keep_byte                = 1'b0;
    frame_ok_next            = 1'b0;
    result_fire              = 1'b0;
    unique case (state)
      S_HUNT: begin
        if (b == scfr_pkg::HDR_BYTE) begin
          state_next               = S_ADDR;
          running_sum_next         = b;
          running_sum_of_sums_next = b;
        end
      end
      S_ADDR: begin
        if (b == own_address || b == broadcast_address) begin
          state_next               = S_FUNC;
          running_sum_next         = sum_add;
          running_sum_of_sums_next = sos_add;
        end else begin
          state_next = S_HUNT;
        end
      end
      S_FUNC: begin
        state_next               = S_LEN;
        function_id_next         = b;
        running_sum_next         = sum_add;
        running_sum_of_sums_next = sos_add;
      end
      S_LEN: begin
        if (b < scfr_pkg::LEN_LIMIT) begin
          state_next               = S_PAYLOAD;
          bytes_remaining_next     = b;
          payload_index_next       = 3'd0;
          running_sum_next         = sum_add;
          running_sum_of_sums_next = sos_add;
        end else begin
          state_next = S_HUNT;
        end
      end
      S_PAYLOAD: begin
        if (bytes_remaining != 8'd0) begin
          bytes_remaining_next     = bytes_remaining - 8'd1;
          keep_byte                = 1'b1;
          running_sum_next         = sum_add;
          running_sum_of_sums_next = sos_add;
          if (bytes_remaining == 8'd1) begin
            state_next = S_SUM;
          end
        end else begin
          // A zero-length frame drops this byte
          state_next = S_HUNT;
        end
      end
      S_SUM: begin
        state_next       = S_SUMSUM;
        sum_matched_next = (b == running_sum);
        keep_byte        = 1'b1;
      end
      S_SUMSUM: begin
        state_next    = S_HUNT;
        keep_byte     = 1'b1;
        frame_ok_next = sum_matched && (b == running_sum_of_sums);
        result_fire   = 1'b1;
      end
      default: begin
        state_next = S_HUNT;
      end
    endcase

    // Window keeps frame bytes 4 to 7; the index saturates once past them
    window_next = window;
    if (keep_byte && !payload_index[2]) begin
      window_next[payload_index[1:0]] = b;
    end
    if (keep_byte && !payload_index[2]) begin
      payload_index_next = payload_index + 3'd1;
    end
  end

  scfr_decode u_decode (
    .window      (window_next),
    .record      (record),
    .record_next (record_upd)
  );

  // Only a good tracking frame touches the record
  always_comb begin
    record_next = record;
    if (result_fire && frame_ok_next && function_id == scfr_pkg::FUNC_TRACK) begin
      record_next = record_upd;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address       <= 8'd0;
      broadcast_address <= 8'd255;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        scfr_pkg::CFG_OWN_ADDR:   own_address       <= cfg.data;
        scfr_pkg::CFG_BCAST_ADDR: broadcast_address <= cfg.data;
        default:                  own_address       <= own_address;
      endcase
    end
  end

  // Parser state, window and record
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_HUNT;
      bytes_remaining     <= 8'd0;
      payload_index       <= 3'd0;
      running_sum         <= 8'd0;
      running_sum_of_sums <= 8'd0;
      function_id         <= 8'd0;
      sum_matched         <= 1'b0;
      window              <= '0;
      record              <= '0;
    end else if (rx_take) begin
      state               <= state_next;
      bytes_remaining     <= bytes_remaining_next;
      payload_index       <= payload_index_next;
      running_sum         <= running_sum_next;
      running_sum_of_sums <= running_sum_of_sums_next;
      function_id         <= function_id_next;
      sum_matched         <= sum_matched_next;
      window              <= window_next;
      record              <= record_next;
    end
  end

  // Result register; the record only changes when a new result is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rx_take && result_fire) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take && result_fire) begin
      frame_ok <= frame_ok_next;
    end
  end

  assign res.valid             = res_valid;
  assign res.frame_ok          = frame_ok;
  assign res.turn_direction    = record.turn_direction;
  assign res.turn_angle        = record.turn_angle;
  assign res.x_direction       = record.x_direction;
  assign res.x_offset          = record.x_offset;
  assign res.y_direction       = record.y_direction;
  assign res.y_offset          = record.y_offset;
  assign res.distance_units    = record.distance_units;
  assign res.recognized_number = record.recognized_number;
  assign res.work_mode         = record.work_mode;
  assign res.update_count      = record.update_count;

endmodule

// ===== sv/scfr_checker.sv =====
module scfr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        rx_valid,
  input logic                        rx_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [scfr_pkg::DIST_W-1:0] distance_units,
  input logic [7:0]                  update_count
);

  // A waiting result is held until it is taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before it was taken");

  // No byte is taken while a result is stalled at the output
  a_rx_backpressure: assert property (@(posedge clk) disable iff (rst)
    rx_valid && rx_ready |-> !(res_valid && !res_ready))
    else $error("byte taken while a result was stalled");

  // The update count moves only together with a fresh result
  a_count_with_result: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && update_count != $past(update_count) |-> res_valid)
    else $error("record changed without a result");

  // A distance scaled by ten never exceeds the 16-bit maximum over ten
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> distance_units <= 13'd6553)
    else $error("distance out of range");

endmodule

bind sum_checked_frame_receiver_top scfr_checker u_scfr_checker (
  .clk            (clk),
  .rst            (rst),
  .rx_valid       (rx.valid),
  .rx_ready       (rx.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .distance_units (res.distance_units),
  .update_count   (res.update_count)
);
